FILE: rtl/lhnc_pkg.sv
// Shared types, character constants and helper functions for the local host name checker.
// Depends on nothing; every other file but lhnc_out_if imports it.
package lhnc_pkg;

  localparam int CH_W    = 8;
  localparam int TAIL_W  = 48;
  localparam int OCT_W   = 9;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [CFG_AW-3:0] REG_LOOPBACK = 1'b0;

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_LZ     = 8'h7A;

  localparam logic [TAIL_W-1:0] TAIL_LOCAL    = 48'h2E6C6F63616C;
  localparam int                LOCALHOST_LEN = 9;
  localparam int                LOCAL_LEN     = 6;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
    logic            end_only;
  } lhnc_word_t;

  function automatic logic [7:0] localhost_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h6C;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h63;
      4'd3:    c = 8'h61;
      4'd4:    c = 8'h6C;
      4'd5:    c = 8'h68;
      4'd6:    c = 8'h6F;
      4'd7:    c = 8'h73;
      4'd8:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic octet_ok(input logic [OCT_W-1:0] value, input logic [1:0] len,
                                    input logic lead_zero);
    return (len != 2'd0) && !(lead_zero && (len > 2'd1)) && (value <= 9'd255);
  endfunction

endpackage

FILE: rtl/lhnc_in_if.sv
// Input channel: one host name character per word, valid/ready handshake.
// Depends on lhnc_pkg.
interface lhnc_in_if import lhnc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;
  logic            end_only;

  modport source (output valid, ch, last, end_only, input ready);
  modport sink   (input valid, ch, last, end_only, output ready);
endinterface

FILE: rtl/lhnc_out_if.sv
// Result channel: one verdict word per closed host name, valid/ready handshake.
// Depends on nothing.
interface lhnc_out_if ();
  logic valid;
  logic ready;
  logic accepted;

  modport source (output valid, accepted, input ready);
  modport sink   (input valid, accepted, output ready);
endinterface

FILE: rtl/lhnc_apb.sv
// APB-style configuration register: holds the loopback enable.
// Depends on lhnc_pkg.
module lhnc_apb import lhnc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic              loopback
);

  logic loopback_r;
  logic loopback_nxt;

  always_comb begin
    loopback_nxt = loopback_r;
    if (psel && penable && pwrite && (paddr[CFG_AW-1:2] == REG_LOOPBACK)) begin
      loopback_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loopback_r <= 1'b0;
    end else begin
      loopback_r <= loopback_nxt;
    end
  end

  assign pready   = 1'b1;
  assign prdata   = (paddr[CFG_AW-1:2] == REG_LOOPBACK) ? {{(CFG_DW-1){1'b0}}, loopback_r}
                                                        : '0;
  assign loopback = loopback_r;

endmodule

FILE: rtl/lhnc_scan.sv
// Per-name scan state: counters and flags updated one character a word, plus the verdict.
// Depends on lhnc_pkg.
module lhnc_scan import lhnc_pkg::*; #(
  parameter int MAX_HOST_LEN  = 128,
  parameter int MAX_LABEL_LEN = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  lhnc_word_t word,
  input  logic       loopback,
  output logic       verdict
);

  localparam int CC_W = $clog2(MAX_HOST_LEN + 2);
  localparam int LL_W = $clog2(MAX_LABEL_LEN + 2);

  logic [CC_W-1:0]   char_count_r, char_count_nxt;
  logic              all_numeric_r, all_numeric_nxt;
  logic [2:0]        dot_count_r, dot_count_nxt;
  logic [OCT_W-1:0]  octet_value_r, octet_value_nxt;
  logic [1:0]        octet_len_r, octet_len_nxt;
  logic              octet_lead_zero_r, octet_lead_zero_nxt;
  logic [7:0]        first_octet_r, first_octet_nxt;
  logic [7:0]        second_octet_r, second_octet_nxt;
  logic              quad_bad_r, quad_bad_nxt;
  logic [LL_W-1:0]   label_len_r, label_len_nxt;
  logic              label_bad_r, label_bad_nxt;
  logic              prev_hyphen_r, prev_hyphen_nxt;
  logic              dot_seen_r, dot_seen_nxt;
  logic [TAIL_W-1:0] tail_chars_r, tail_chars_nxt;
  logic              localhost_match_r, localhost_match_nxt;
  logic              hex_form_r, hex_form_nxt;

  logic [7:0]  c;
  logic        is_digit, is_lower, is_hex, is_dot, is_hyphen;
  logic [11:0] oct_calc;
  logic        close;

  assign c         = word.ch;
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_lower  = (c >= CH_LA) && (c <= CH_LZ);
  assign is_hex    = is_digit || ((c >= CH_LA) && (c <= CH_LF));
  assign is_dot    = (c == CH_DOT);
  assign is_hyphen = (c == CH_HYPHEN);
  assign oct_calc  = {3'b000, octet_value_r} * 12'd10 + {4'h0, c - CH_ZERO};
  assign close     = word.last || word.end_only;

  always_comb begin
    char_count_nxt      = char_count_r;
    all_numeric_nxt     = all_numeric_r;
    dot_count_nxt       = dot_count_r;
    octet_value_nxt     = octet_value_r;
    octet_len_nxt       = octet_len_r;
    octet_lead_zero_nxt = octet_lead_zero_r;
    first_octet_nxt     = first_octet_r;
    second_octet_nxt    = second_octet_r;
    quad_bad_nxt        = quad_bad_r;
    label_len_nxt       = label_len_r;
    label_bad_nxt       = label_bad_r;
    prev_hyphen_nxt     = prev_hyphen_r;
    dot_seen_nxt        = dot_seen_r;
    tail_chars_nxt      = tail_chars_r;
    localhost_match_nxt = localhost_match_r;
    hex_form_nxt        = hex_form_r;
    if (!word.end_only) begin
      if (char_count_r <= CC_W'(MAX_HOST_LEN)) begin
        char_count_nxt = char_count_r + 1'b1;
      end
      if (!is_digit && !is_dot) begin
        all_numeric_nxt = 1'b0;
      end
      if (char_count_r < CC_W'(LOCALHOST_LEN)) begin
        if (c != localhost_char(char_count_r[3:0])) begin
          localhost_match_nxt = 1'b0;
        end
      end else begin
        localhost_match_nxt = 1'b0;
      end
      priority if (char_count_r == '0) begin
        if (c != CH_ZERO) hex_form_nxt = 1'b0;
      end else if (char_count_r == CC_W'(1)) begin
        if (c != CH_LX) hex_form_nxt = 1'b0;
      end else begin
        if (!is_hex) hex_form_nxt = 1'b0;
      end
      tail_chars_nxt = {tail_chars_r[TAIL_W-9:0], c};
      if (is_dot) begin
        if (!octet_ok(octet_value_r, octet_len_r, octet_lead_zero_r)) quad_bad_nxt = 1'b1;
        if (dot_count_r == 3'd0) first_octet_nxt = octet_value_r[7:0];
        if (dot_count_r == 3'd1) second_octet_nxt = octet_value_r[7:0];
        if (dot_count_r >= 3'd3) quad_bad_nxt = 1'b1;
        if (dot_count_r != 3'd7) dot_count_nxt = dot_count_r + 1'b1;
        octet_value_nxt     = '0;
        octet_len_nxt       = 2'd0;
        octet_lead_zero_nxt = 1'b0;
        if ((label_len_r == '0) || (label_len_r > LL_W'(MAX_LABEL_LEN)) || prev_hyphen_r) begin
          label_bad_nxt = 1'b1;
        end
        label_len_nxt   = '0;
        prev_hyphen_nxt = 1'b0;
        dot_seen_nxt    = 1'b1;
      end else begin
        if (is_digit) begin
          if ((octet_len_r == 2'd0) && (c == CH_ZERO)) octet_lead_zero_nxt = 1'b1;
          octet_value_nxt = (oct_calc > 12'd256) ? 9'd256 : oct_calc[OCT_W-1:0];
          if (octet_len_r != 2'd3) octet_len_nxt = octet_len_r + 1'b1;
        end
        if (!(is_lower || is_digit || is_hyphen)) label_bad_nxt = 1'b1;
        if ((label_len_r == '0) && is_hyphen) label_bad_nxt = 1'b1;
        if (label_len_r <= LL_W'(MAX_LABEL_LEN)) label_len_nxt = label_len_r + 1'b1;
        prev_hyphen_nxt = is_hyphen;
      end
    end
  end

  always_comb begin
    priority if ((char_count_nxt == '0) || (char_count_nxt > CC_W'(MAX_HOST_LEN))) begin
      verdict = 1'b0;
    end else if (all_numeric_nxt) begin
      verdict = !quad_bad_nxt && (dot_count_nxt == 3'd3)
             && octet_ok(octet_value_nxt, octet_len_nxt, octet_lead_zero_nxt)
             && ((first_octet_nxt == 8'd10)
              || ((first_octet_nxt == 8'd172) && (second_octet_nxt >= 8'd16)
                  && (second_octet_nxt <= 8'd31))
              || ((first_octet_nxt == 8'd192) && (second_octet_nxt == 8'd168))
              || ((first_octet_nxt == 8'd169) && (second_octet_nxt == 8'd254))
              || (loopback && (first_octet_nxt == 8'd127)));
    end else if (localhost_match_nxt && (char_count_nxt == CC_W'(LOCALHOST_LEN))) begin
      verdict = loopback;
    end else if (hex_form_nxt && (char_count_nxt >= CC_W'(2))) begin
      verdict = 1'b0;
    end else if (dot_seen_nxt && !((char_count_nxt >= CC_W'(LOCAL_LEN))
                                   && (tail_chars_nxt == TAIL_LOCAL))) begin
      verdict = 1'b0;
    end else if (label_bad_nxt) begin
      verdict = 1'b0;
    end else begin
      verdict = !((label_len_nxt == '0) || (label_len_nxt > LL_W'(MAX_LABEL_LEN))
                  || prev_hyphen_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && close)) begin
      char_count_r      <= '0;
      all_numeric_r     <= 1'b1;
      dot_count_r       <= 3'd0;
      octet_value_r     <= '0;
      octet_len_r       <= 2'd0;
      octet_lead_zero_r <= 1'b0;
      first_octet_r     <= 8'd0;
      second_octet_r    <= 8'd0;
      quad_bad_r        <= 1'b0;
      label_len_r       <= '0;
      label_bad_r       <= 1'b0;
      prev_hyphen_r     <= 1'b0;
      dot_seen_r        <= 1'b0;
      tail_chars_r      <= '0;
      localhost_match_r <= 1'b1;
      hex_form_r        <= 1'b1;
    end else if (take) begin
      char_count_r      <= char_count_nxt;
      all_numeric_r     <= all_numeric_nxt;
      dot_count_r       <= dot_count_nxt;
      octet_value_r     <= octet_value_nxt;
      octet_len_r       <= octet_len_nxt;
      octet_lead_zero_r <= octet_lead_zero_nxt;
      first_octet_r     <= first_octet_nxt;
      second_octet_r    <= second_octet_nxt;
      quad_bad_r        <= quad_bad_nxt;
      label_len_r       <= label_len_nxt;
      label_bad_r       <= label_bad_nxt;
      prev_hyphen_r     <= prev_hyphen_nxt;
      dot_seen_r        <= dot_seen_nxt;
      tail_chars_r      <= tail_chars_nxt;
      localhost_match_r <= localhost_match_nxt;
      hex_form_r        <= hex_form_nxt;
    end
  end

endmodule

FILE: rtl/local_host_name_checker.sv
// Local host name checker top level: input register, scan state, verdict register.
// A closing word's verdict is registered for out_word once the verdict register is free.
// One word per cycle; a closing word stalls only while an untaken verdict is held.
// Reset: synchronous, active low; clears the scan state, both valid flags and loopback enable.
// Depends on lhnc_pkg, lhnc_in_if, lhnc_out_if, lhnc_apb and lhnc_scan.
module local_host_name_checker import lhnc_pkg::*; #(
  parameter int MAX_HOST_LEN  = 128,
  parameter int MAX_LABEL_LEN = 63
) (
  input  logic              clk,
  input  logic              rst_n,
  lhnc_in_if.sink           in_word,
  lhnc_out_if.source        out_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic       s1_valid_r;
  lhnc_word_t s1_word_r;
  logic       out_valid_r;
  logic       out_accepted_r;
  logic       out_free;
  logic       s1_close;
  logic       s1_go;
  logic       verdict;
  logic       loopback;

  lhnc_apb u_apb (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .loopback (loopback)
  );

  lhnc_scan #(
    .MAX_HOST_LEN  (MAX_HOST_LEN),
    .MAX_LABEL_LEN (MAX_LABEL_LEN)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (s1_go),
    .word     (s1_word_r),
    .loopback (loopback),
    .verdict  (verdict)
  );

  assign out_free      = !out_valid_r || out_word.ready;
  assign s1_close      = s1_word_r.last || s1_word_r.end_only;
  assign s1_go         = s1_valid_r && (!s1_close || out_free);
  assign in_word.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_word.ready) begin
      s1_valid_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_word.ready && in_word.valid) begin
      s1_word_r <= '{ch: in_word.ch, last: in_word.last, end_only: in_word.end_only};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_close) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_close) begin
      out_accepted_r <= verdict;
    end
  end

  assign out_word.valid    = out_valid_r;
  assign out_word.accepted = out_accepted_r;

`ifndef SYNTHESIS
  a_close_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_close |=> out_valid_r)
    else $error("closing word did not reach the verdict register");

  a_out_from_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(out_valid_r) |-> $past(s1_go && s1_close))
    else $error("verdict appeared without a closing word");

  a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_close && !out_free |=> s1_valid_r && $stable(s1_word_r))
    else $error("blocked closing word was lost");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_word.ready |-> s1_valid_r && s1_close && out_valid_r)
    else $error("input stalled without a pending verdict");
`endif

endmodule
